>>> rtl/abkf_pkg.sv
// abkf_pkg: shared types and constants for the angle/bias Kalman filter core.
// No dependencies; used by the core top level and the testbench.
package abkf_pkg;

    localparam logic [1:0] REG_Q_ANGLE    = 2'd0;
    localparam logic [1:0] REG_Q_BIAS     = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

    localparam logic [31:0] RST_Q_ANGLE    = 32'd4294967;
    localparam logic [31:0] RST_Q_BIAS     = 32'd12884902;
    localparam logic [31:0] RST_MEAS_NOISE = 32'd128849019;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_P1, S_P2, S_P3, S_P4, S_P5,
        S_D0, S_D1,
        S_U0, S_U1, S_U2, S_U3, S_U4, S_U5,
        S_OUT
    } t_state;

endpackage

>>> rtl/abkf_mul.sv
// abkf_mul: iterative signed multiplier, (a*b)>>sh truncated toward zero,
// saturated to W bits. No dependencies. Radix-2 shift-add, one bit a cycle.
module abkf_mul #(
    parameter int W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_gain,      // 1: shift 32, 0: shift 16
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic             o_busy,
    output logic             o_done,
    output logic signed [W-1:0] o_p
);
    localparam int CW = $clog2(W + 1);
    localparam int PW = 2 * W;

    logic [W-1:0]  r_ma, r_mb;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, r_neg, r_gain;
    logic signed [W-1:0] r_p;

    logic [W-1:0]  w_ua, w_ub;
    logic [PW-1:0] w_sh, w_res;
    logic          w_big;
    logic [W-1:0]  w_max;

    assign w_ua = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_ub = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign w_sh = r_gain ? (r_acc >> 32) : (r_acc >> 16);
    assign w_max = {1'b0, {(W-1){1'b1}}};
    assign w_big = r_neg ? (w_sh > PW'(w_max) + PW'(1)) : (w_sh > PW'(w_max));

    always_comb begin
        if (w_big) begin
            w_res = r_neg ? PW'(~w_max) : PW'(w_max);
        end else begin
            w_res = r_neg ? (~w_sh + 1'b1) : w_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_acc  <= '0;
                r_ma   <= w_ua;
                r_mb   <= w_ub;
                r_neg  <= i_a[W-1] ^ i_b[W-1];
                r_gain <= i_gain;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_p    <= w_res[W-1:0];
                end else begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + (PW'(r_ma) << (W - r_cnt));
                    end
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_p;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("mul done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |=> r_busy || o_done) else $error("mul dropped busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("mul done held");
endmodule

>>> rtl/abkf_div.sv
// abkf_div: restoring divider, (n*2^32)/d toward zero, saturated, 0 if d==0.
// Depends on nothing beyond its ports. One quotient bit a cycle.
module abkf_div #(
    parameter int W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic signed [W-1:0] i_n,
    input  logic signed [W-1:0] i_d,
    output logic             o_busy,
    output logic             o_done,
    output logic signed [W-1:0] o_q
);
    localparam int NW = W + 32;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, r_quo;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, r_neg, r_zero;
    logic signed [W-1:0] r_q;

    logic [W-1:0] w_un, w_ud, w_max;
    logic [W:0]   w_rs;
    logic         w_big;
    logic [NW-1:0] w_qs;

    assign w_un  = i_n[W-1] ? (~i_n + 1'b1) : i_n;
    assign w_ud  = i_d[W-1] ? (~i_d + 1'b1) : i_d;
    assign w_rs  = {r_rem[W-1:0], r_num[NW-1]};
    assign w_max = {1'b0, {(W-1){1'b1}}};
    assign w_big = r_neg ? (r_quo > NW'(w_max) + NW'(1)) : (r_quo > NW'(w_max));
    assign w_qs  = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= {w_un, 32'd0};
                r_rem  <= '0;
                r_quo  <= '0;
                r_d    <= w_ud;
                r_neg  <= i_n[W-1] ^ i_d[W-1];
                r_zero <= (i_d == '0);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_zero) begin
                        r_q <= '0;
                    end else if (w_big) begin
                        r_q <= r_neg ? ~w_max : w_max;
                    end else begin
                        r_q <= w_qs[W-1:0];
                    end
                end else begin
                    r_num <= r_num << 1;
                    if (w_rs >= {1'b0, r_d}) begin
                        r_rem <= w_rs - {1'b0, r_d};
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rs;
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("div done without busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_zero |-> r_rem < {1'b0, r_d}) else $error("div remainder too big");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("div done held");
endmodule

>>> rtl/angle_bias_kalman_filter_core.sv
// angle_bias_kalman_filter_core: top level of the two-state angle/gyro-bias
// Kalman filter. Depends on abkf_pkg, abkf_mul and abkf_div.
//
// Fuses an accelerometer tilt angle (Q9.16) with a gyro rate (Q10.16) over a
// time step dt (Q0.16) and returns the filtered angle (Q16.16, floor of the
// internal Q.32 estimate, saturated to 32 bits). State is Q(W-32).32 with
// saturation on every operation. The first word after reset loads the angle;
// it passes through accept, load and output states. Every later word runs
// predict and update on a single shared bit-serial multiplier (11 products)
// and a bit-serial divider (two gains). o_ready is low for the whole
// computation; the result sits in an output register and the next word may be
// accepted while it waits. Only if that result is still unread when the next
// one is due does the core stall. Configuration writes land at once
// (index 3 ignored).
module angle_bias_kalman_filter_core #(
    parameter int INTERNAL_WIDTH = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [24:0] i_accel_angle,
    input  logic signed [25:0] i_gyro_rate,
    input  logic        [15:0] i_time_step,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_fused_angle,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data
);
    localparam int W = INTERNAL_WIDTH;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    // 32-bit output limits at the internal width
    localparam logic signed [W-1:0] OMAX = W'(64'sh7FFF_FFFF);
    localparam logic signed [W-1:0] OMIN = W'(-64'sh8000_0000);

    abkf_pkg::t_state r_state, n_state;

    // configuration
    logic [31:0] r_q_angle, r_q_bias, r_meas_noise;

    // filter state
    logic signed [W-1:0] r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic                r_started;
    // sample and temporaries
    logic signed [W-1:0] r_acc, r_gyr, r_dt, r_t, r_k0, r_k1, r_y, r_p00, r_p01;
    logic                r_kdone;

    // output word register
    logic                r_ovalid;
    logic signed [31:0]  r_out;

    // shared units
    logic                w_mstart, w_mbusy, w_mdone;
    logic                w_dstart, w_dbusy, w_ddone;
    logic                w_mgain;
    logic signed [W-1:0] w_ma, w_mb, w_mp, w_dn, w_dd, w_dq;

    // sub-step flag: unit launched for this state already
    logic r_launched;
    // output register free this cycle
    logic w_out_go;

    // saturating add/sub: overflow when the two top bits differ
    function automatic logic signed [W-1:0] f_sat(input logic signed [W:0] v);
        if (!v[W] && v[W-1]) begin
            f_sat = WMAX;
        end else if (v[W] && !v[W-1]) begin
            f_sat = WMIN;
        end else begin
            f_sat = v[W-1:0];
        end
    endfunction

    function automatic logic signed [W-1:0] f_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        f_add = f_sat({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic signed [W-1:0] f_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        f_sub = f_sat({a[W-1], a} - {b[W-1], b});
    endfunction

    // emit: floor >> 16, saturate to 32 bits
    function automatic logic signed [31:0] f_emit(input logic signed [W-1:0] v);
        logic signed [W-1:0] s;
        s = v >>> 16;
        if (s > OMAX) begin
            f_emit = 32'sh7FFF_FFFF;
        end else if (s < OMIN) begin
            f_emit = 32'sh8000_0000;
        end else begin
            f_emit = s[31:0];
        end
    endfunction

    // widen a Q10.16 input to Q.32, saturating at the internal width
    function automatic logic signed [W-1:0] f_widen(input logic signed [25:0] v);
        logic signed [W+25:0] x;
        x = (W+26)'(v) <<< 16;
        if (x > (W+26)'(WMAX)) begin
            f_widen = WMAX;
        end else if (x < (W+26)'(WMIN)) begin
            f_widen = WMIN;
        end else begin
            f_widen = x[W-1:0];
        end
    endfunction

    abkf_mul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart), .i_gain(w_mgain),
        .i_a(w_ma), .i_b(w_mb), .o_busy(w_mbusy), .o_done(w_mdone), .o_p(w_mp)
    );

    abkf_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_n(w_dn), .i_d(w_dd), .o_busy(w_dbusy), .o_done(w_ddone), .o_q(w_dq)
    );

    assign o_ready       = (r_state == abkf_pkg::S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_fused_angle = r_out;
    assign w_out_go      = !r_ovalid || i_ready;

    // multiplier operand selection per state; the step starts on entry
    always_comb begin
        w_mgain = 1'b0;
        w_ma    = r_dt;
        w_mb    = r_pbb;
        case (r_state)
            abkf_pkg::S_P1: w_mb = f_sub(r_gyr, r_bias);
            abkf_pkg::S_P2: w_mb = r_pbb;
            abkf_pkg::S_P3: w_mb = r_t;
            abkf_pkg::S_P4: w_mb = r_pbb;
            abkf_pkg::S_P5: w_mb = W'({1'b0, r_q_bias});
            abkf_pkg::S_U0: begin w_mgain = 1'b1; w_ma = r_k0; w_mb = r_y; end
            abkf_pkg::S_U1: begin w_mgain = 1'b1; w_ma = r_k1; w_mb = r_y; end
            abkf_pkg::S_U2: begin w_mgain = 1'b1; w_ma = r_k0; w_mb = r_p00; end
            abkf_pkg::S_U3: begin w_mgain = 1'b1; w_ma = r_k0; w_mb = r_p01; end
            abkf_pkg::S_U4: begin w_mgain = 1'b1; w_ma = r_k1; w_mb = r_p00; end
            abkf_pkg::S_U5: begin w_mgain = 1'b1; w_ma = r_k1; w_mb = r_p01; end
            default: ;
        endcase
        w_dn = r_kdone ? r_pba : r_paa;
        w_dd = f_add(r_paa, W'({1'b0, r_meas_noise}));
    end

    always_comb begin
        w_mstart = (r_state inside {abkf_pkg::S_P1, abkf_pkg::S_P2, abkf_pkg::S_P3,
                                    abkf_pkg::S_P4, abkf_pkg::S_P5, abkf_pkg::S_U0,
                                    abkf_pkg::S_U1, abkf_pkg::S_U2, abkf_pkg::S_U3,
                                    abkf_pkg::S_U4, abkf_pkg::S_U5})
                   && !r_launched;
        w_dstart = (r_state inside {abkf_pkg::S_D0, abkf_pkg::S_D1}) && !r_launched;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            abkf_pkg::S_IDLE:
                if (i_valid && o_ready) begin
                    n_state = r_started ? abkf_pkg::S_P1 : abkf_pkg::S_INIT;
                end
            abkf_pkg::S_INIT: n_state = abkf_pkg::S_OUT;
            abkf_pkg::S_P1: if (w_mdone) n_state = abkf_pkg::S_P2;
            abkf_pkg::S_P2: if (w_mdone) n_state = abkf_pkg::S_P3;
            abkf_pkg::S_P3: if (w_mdone) n_state = abkf_pkg::S_P4;
            abkf_pkg::S_P4: if (w_mdone) n_state = abkf_pkg::S_P5;
            abkf_pkg::S_P5: if (w_mdone) n_state = abkf_pkg::S_D0;
            abkf_pkg::S_D0: if (w_ddone) n_state = abkf_pkg::S_D1;
            abkf_pkg::S_D1: if (w_ddone) n_state = abkf_pkg::S_U0;
            abkf_pkg::S_U0: if (w_mdone) n_state = abkf_pkg::S_U1;
            abkf_pkg::S_U1: if (w_mdone) n_state = abkf_pkg::S_U2;
            abkf_pkg::S_U2: if (w_mdone) n_state = abkf_pkg::S_U3;
            abkf_pkg::S_U3: if (w_mdone) n_state = abkf_pkg::S_U4;
            abkf_pkg::S_U4: if (w_mdone) n_state = abkf_pkg::S_U5;
            abkf_pkg::S_U5: if (w_mdone) n_state = abkf_pkg::S_OUT;
            // wait here while the previous result is still unread
            abkf_pkg::S_OUT: if (w_out_go) n_state = abkf_pkg::S_IDLE;
            default: n_state = abkf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abkf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_angle    <= abkf_pkg::RST_Q_ANGLE;
            r_q_bias     <= abkf_pkg::RST_Q_BIAS;
            r_meas_noise <= abkf_pkg::RST_MEAS_NOISE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                abkf_pkg::REG_Q_ANGLE:    r_q_angle    <= i_cfg_data;
                abkf_pkg::REG_Q_BIAS:     r_q_bias     <= i_cfg_data;
                abkf_pkg::REG_MEAS_NOISE: r_meas_noise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath: state updates as each shared-unit result returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_launched <= 1'b0;
            r_kdone    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_ang <= '0; r_bias <= '0;
            r_paa <= '0; r_pab <= '0; r_pba <= '0; r_pbb <= '0;
        end else begin
            if (r_state == abkf_pkg::S_OUT && w_out_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_mstart || w_dstart) begin
                r_launched <= 1'b1;
            end else if (w_mdone || w_ddone) begin
                r_launched <= 1'b0;
            end
            case (r_state)
                abkf_pkg::S_IDLE:
                    if (i_valid && o_ready) begin
                        r_acc   <= f_widen({i_accel_angle[24], i_accel_angle});
                        r_gyr   <= f_widen(i_gyro_rate);
                        r_dt    <= W'({1'b0, i_time_step});
                        r_kdone <= 1'b0;
                    end
                abkf_pkg::S_INIT: begin
                    r_ang <= r_acc; r_bias <= '0;
                    r_paa <= '0; r_pab <= '0; r_pba <= '0; r_pbb <= '0;
                    r_started <= 1'b1;
                end
                abkf_pkg::S_P1: if (w_mdone) r_ang <= f_add(r_ang, w_mp);
                abkf_pkg::S_P2: if (w_mdone) r_t <= f_add(f_sub(f_sub(w_mp, r_pab),
                                     r_pba), W'({1'b0, r_q_angle}));
                abkf_pkg::S_P3: if (w_mdone) r_paa <= f_add(r_paa, w_mp);
                abkf_pkg::S_P4: if (w_mdone) begin
                    r_pab <= f_sub(r_pab, w_mp);
                    r_pba <= f_sub(r_pba, w_mp);
                end
                abkf_pkg::S_P5: if (w_mdone) r_pbb <= f_add(r_pbb, w_mp);
                abkf_pkg::S_D0: if (w_ddone) begin r_k0 <= w_dq; r_kdone <= 1'b1; end
                abkf_pkg::S_D1: if (w_ddone) begin
                    r_k1  <= w_dq;
                    r_y   <= f_sub(r_acc, r_ang);
                    r_p00 <= r_paa;
                    r_p01 <= r_pab;
                end
                abkf_pkg::S_U0: if (w_mdone) r_ang  <= f_add(r_ang, w_mp);
                abkf_pkg::S_U1: if (w_mdone) r_bias <= f_add(r_bias, w_mp);
                abkf_pkg::S_U2: if (w_mdone) r_paa  <= f_sub(r_paa, w_mp);
                abkf_pkg::S_U3: if (w_mdone) r_pab  <= f_sub(r_pab, w_mp);
                abkf_pkg::S_U4: if (w_mdone) r_pba  <= f_sub(r_pba, w_mp);
                abkf_pkg::S_U5: if (w_mdone) r_pbb  <= f_sub(r_pbb, w_mp);
                abkf_pkg::S_OUT:
                    if (w_out_go) begin
                        r_out <= f_emit(r_ang);
                    end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_out))
        else $error("result overwritten");
    a_unit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mbusy && w_dbusy)) else $error("both units busy");
    a_init_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == abkf_pkg::S_INIT |-> !r_started) else $error("re-init");
endmodule

>>> tb/tb.sv
// tb: self-checking testbench for angle_bias_kalman_filter_core.
// Depends on abkf_pkg and the core RTL; holds its own fixed-point filter predictor,
// a queue-fed driver, a checking monitor and phases of register settings.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Internal state is 48-bit signed Q16.32, saturated on every operation
    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000_0000;

    typedef struct packed {
        logic signed [24:0] accel;
        logic signed [25:0] gyro;
        logic        [15:0] dt;
    } t_sample;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [24:0] accel_angle;
    logic signed [25:0] gyro_rate;
    logic        [15:0] time_step;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] fused_angle;
    logic               cfg_we;
    logic        [1:0]  cfg_index;
    logic        [31:0] cfg_data;

    angle_bias_kalman_filter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_accel_angle (accel_angle),
        .i_gyro_rate   (gyro_rate),
        .i_time_step   (time_step),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_fused_angle (fused_angle),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // Predictor copy of the filter state and register settings
    logic [31:0]        noise_angle, noise_bias, noise_meas;
    logic signed [63:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    logic               filt_started;

    t_sample            pending_words[$];
    logic signed [31:0] expected_angles[$];
    int                 fail_count;
    int                 words_out;
    bit                 idling_on;

    // ---------------------------------------------------------------------
    // Saturating fixed-point helpers
    // ---------------------------------------------------------------------
    function automatic logic signed [63:0] sat_w(input logic signed [127:0] v);
        if (v > SAT_HI) return SAT_HI[63:0];
        if (v < SAT_LO) return SAT_LO[63:0];
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return sat_w(wa + wb);
    endfunction

    function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return sat_w(wa - wb);
    endfunction

    // (a*b) >> sh, truncated toward zero
    function automatic logic signed [63:0] mul_s(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int sh);
        logic signed [127:0] wa, wb, prod;
        wa = a;
        wb = b;
        if (wa < 0) wa = -wa;
        if (wb < 0) wb = -wb;
        prod = (wa * wb) >>> sh;
        if ((a < 0) != (b < 0)) prod = -prod;
        return sat_w(prod);
    endfunction

    // (n << 32) / d, truncated toward zero; zero divisor gives a zero gain
    function automatic logic signed [63:0] gain_s(input logic signed [63:0] n,
                                                  input logic signed [63:0] d);
        logic signed [127:0] wn, wd, q;
        if (d == 0) return 64'sd0;
        wn = n;
        wd = d;
        if (wn < 0) wn = -wn;
        if (wd < 0) wd = -wd;
        q = (wn <<< 32) / wd;
        if ((n < 0) != (d < 0)) q = -q;
        return sat_w(q);
    endfunction

    function automatic logic signed [31:0] to_output(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v >>> 16;
        if (r > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (r < -64'sh8000_0000) return -32'sh8000_0000;
        return r[31:0];
    endfunction

    // One filter step on an accepted word; queues the expected fused angle
    task automatic predict_fused_angle(input t_sample w);
        logic signed [63:0] acc, gyr, dt, t, s, k0, k1, y, p00, p01;
        logic signed [63:0] qa, qb, rm;
        acc = sat_w(128'(w.accel) <<< 16);
        gyr = sat_w(128'(w.gyro) <<< 16);
        dt  = {48'd0, w.dt};
        qa  = {32'd0, noise_angle};
        qb  = {32'd0, noise_bias};
        rm  = {32'd0, noise_meas};
        if (!filt_started) begin
            est_angle = acc;
            est_bias = 0;
            p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
            filt_started = 1'b1;
        end else begin
            // predict
            est_angle = add_s(est_angle, mul_s(dt, sub_s(gyr, est_bias), 16));
            t = mul_s(dt, p_bb, 16);
            t = sub_s(t, p_ab);
            t = sub_s(t, p_ba);
            t = add_s(t, qa);
            p_aa = add_s(p_aa, mul_s(dt, t, 16));
            t = mul_s(dt, p_bb, 16);
            p_ab = sub_s(p_ab, t);
            p_ba = sub_s(p_ba, t);
            p_bb = add_s(p_bb, mul_s(qb, dt, 16));
            // update
            s  = add_s(p_aa, rm);
            k0 = gain_s(p_aa, s);
            k1 = gain_s(p_ba, s);
            y  = sub_s(acc, est_angle);
            est_angle = add_s(est_angle, mul_s(k0, y, 32));
            est_bias  = add_s(est_bias, mul_s(k1, y, 32));
            p00 = p_aa;
            p01 = p_ab;
            p_aa = sub_s(p_aa, mul_s(k0, p00, 32));
            p_ab = sub_s(p_ab, mul_s(k0, p01, 32));
            p_ba = sub_s(p_ba, mul_s(k1, p00, 32));
            p_bb = sub_s(p_bb, mul_s(k1, p01, 32));
        end
        expected_angles.push_back(to_output(est_angle));
    endtask

    // ---------------------------------------------------------------------
    // Clock and run limit
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Driver: takes words from pending_words, random gaps between them
    // ---------------------------------------------------------------------
    int tx_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (in_valid && in_ready)
                predict_fused_angle({accel_angle, gyro_rate, time_step});
            if (!in_valid || in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    t_sample w;
                    w = pending_words.pop_front();
                    accel_angle <= w.accel;
                    gyro_rate   <= w.gyro;
                    time_step   <= w.dt;
                    in_valid    <= 1'b1;
                    if (idling_on && $urandom_range(0, 3) == 0)
                        tx_gap <= $urandom_range(1, 10);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random back-pressure, one long hold, checks each result word
    // ---------------------------------------------------------------------
    int  rx_stall;
    bit  long_hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready      <= 1'b0;
            rx_stall       <= 0;
            long_hold_done <= 1'b0;
            words_out      <= 0;
        end else begin
            if (out_valid && out_ready) begin
                words_out <= words_out + 1;
                if (expected_angles.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0d",
                             $time, fused_angle);
                    fail_count++;
                end else begin
                    logic signed [31:0] exp_a;
                    exp_a = expected_angles.pop_front();
                    if (fused_angle !== exp_a) begin
                        $display("%0t: fused_angle mismatch, expected %0d, actual %0d",
                                 $time, exp_a, fused_angle);
                        fail_count++;
                    end
                end
            end
            // long hold: sender keeps offering, core fills and drops o_ready
            if (!long_hold_done && words_out == 60) begin
                long_hold_done <= 1'b1;
                rx_stall       <= 3000;
                out_ready      <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall  <= rx_stall - 1;
                out_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                rx_stall  <= $urandom_range(0, 9);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    function automatic t_sample make_word(input logic signed [24:0] a,
                                          input logic signed [25:0] g,
                                          input logic [15:0] t);
        t_sample w;
        w.accel = a;
        w.gyro  = g;
        w.dt    = t;
        return w;
    endfunction

    function automatic t_sample random_word();
        t_sample w;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)      w.accel = 25'($signed($urandom_range(0, 23592960)) - 11796480);
        else if (sel < 16) w.accel = (sel == 14) ? 25'sd11796480 : -25'sd11796480;
        else               w.accel = 25'($urandom);
        sel = $urandom_range(0, 19);
        if (sel < 14)      w.gyro = 26'($signed($urandom_range(0, 65536000)) - 32768000);
        else if (sel < 16) w.gyro = (sel == 14) ? 26'sd32768000 : -26'sd32768000;
        else               w.gyro = 26'($urandom);
        sel = $urandom_range(0, 19);
        if (sel < 10)      w.dt = 16'($urandom_range(1, 2000));
        else if (sel < 17) w.dt = 16'($urandom);
        else if (sel < 18) w.dt = 16'd0;
        else               w.dt = 16'hFFFF;
        return w;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            abkf_pkg::REG_Q_ANGLE:    noise_angle = val;
            abkf_pkg::REG_Q_BIAS:     noise_bias  = val;
            abkf_pkg::REG_MEAS_NOISE: noise_meas  = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // all words accepted and all results back, plus a margin for the core
    task automatic wait_drained();
        wait (pending_words.size() == 0 && !in_valid && expected_angles.size() == 0);
        repeat (900) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] qa, input logic [31:0] qb,
                             input logic [31:0] rm, input int n_words);
        wait_drained();
        write_reg(abkf_pkg::REG_Q_ANGLE, qa);
        write_reg(abkf_pkg::REG_Q_BIAS, qb);
        write_reg(abkf_pkg::REG_MEAS_NOISE, rm);
        repeat (n_words) pending_words.push_back(random_word());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        accel_angle  = '0;
        gyro_rate    = '0;
        time_step    = '0;
        cfg_we       = 1'b0;
        cfg_index    = abkf_pkg::REG_Q_ANGLE;
        cfg_data     = '0;
        fail_count   = 0;
        idling_on    = 1'b1;
        noise_angle  = abkf_pkg::RST_Q_ANGLE;
        noise_bias   = abkf_pkg::RST_Q_BIAS;
        noise_meas   = abkf_pkg::RST_MEAS_NOISE;
        est_angle = 0; est_bias = 0;
        p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
        filt_started = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first word loads the angle, then field extremes,
        // zero and full time steps, out-of-range raw patterns
        pending_words.push_back(make_word(25'sd11796480, 26'sd0, 16'd100));
        pending_words.push_back(make_word(-25'sd11796480, 26'sd32768000, 16'd1));
        pending_words.push_back(make_word(25'sd11796480, -26'sd32768000, 16'hFFFF));
        pending_words.push_back(make_word(25'sd0, 26'sd0, 16'd0));
        pending_words.push_back(make_word(25'sd65536, 26'sd131072, 16'd655));
        pending_words.push_back(make_word(25'h0FFFFFF, 26'h1FFFFFF, 16'hFFFF));
        pending_words.push_back(make_word(25'h1000000, 26'h2000000, 16'hFFFF));
        pending_words.push_back(make_word(-25'sd1, -26'sd1, 16'd1));
        pending_words.push_back(make_word(25'sd1, 26'sd1, 16'd0));
        pending_words.push_back(make_word(-25'sd11796480, -26'sd32768000, 16'd32768));
        repeat (6) pending_words.push_back(make_word(25'sd3000000, 26'sd5000, 16'd328));

        // zero divisor: with all noise terms zero a gain of one clears cov_aa,
        // and zero time steps then keep it clear
        run_phase(32'd0, 32'd0, 32'd0, 2);
        pending_words.push_back(make_word(25'sd70000, 26'sd1000, 16'd0));
        pending_words.push_back(make_word(-25'sd70000, -26'sd1000, 16'd0));
        // register extremes and mixes; the long hold falls in the first one
        run_phase(abkf_pkg::RST_Q_ANGLE, abkf_pkg::RST_Q_BIAS,
                  abkf_pkg::RST_MEAS_NOISE, 400);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 200);
        run_phase(32'd0, abkf_pkg::RST_Q_BIAS, 32'd0, 200);
        run_phase(32'hFFFF_FFFF, 32'd0, 32'd1, 200);
        run_phase($urandom, $urandom, $urandom, 200);
        run_phase($urandom, $urandom, $urandom, 200);
        run_phase(32'd1, 32'hFFFF_FFFF, 32'd0, 200);
        // last part with no idling on either side
        wait_drained();
        idling_on = 1'b0;
        write_reg(abkf_pkg::REG_Q_ANGLE, abkf_pkg::RST_Q_ANGLE);
        write_reg(abkf_pkg::REG_Q_BIAS, abkf_pkg::RST_Q_BIAS);
        write_reg(abkf_pkg::REG_MEAS_NOISE, abkf_pkg::RST_MEAS_NOISE);
        repeat (330) pending_words.push_back(random_word());

        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
